FILE: rtl/core/fwbp_pkg.sv
package fwbp_pkg;

    localparam int WordBits  = 64;
    localparam int WidthBits = 7;
    localparam int HeldBits  = 6;
    localparam int BytesBits = 4;

    localparam logic [WidthBits-1:0] WidthReset = 7'd64;
    localparam logic [WidthBits-1:0] WidthMax   = 7'd64;
    localparam logic [BytesBits-1:0] FullBytes  = 4'd8;

    // Queue between the front and the back. The depth must be a power of two.
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);

    typedef struct packed {
        logic [WordBits-1:0] value;
        logic                last;
    } in_t;

    typedef struct packed {
        logic [WordBits-1:0]  word;
        logic [BytesBits-1:0] bytes_valid;
        logic                 final_res;
    } out_t;

    // Results of one accepted item: one or two output words.
    typedef struct packed {
        out_t first;
        out_t second;
        logic two;
    } entry_t;

endpackage

FILE: rtl/core/fwbp_front.sv
module fwbp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [fwbp_pkg::WidthBits-1:0] cfg_data,
    input  logic                        in_valid,
    input  fwbp_pkg::in_t               in_data,
    output logic                        in_stall,
    input  logic                        queue_full,
    output logic                        push,
    output fwbp_pkg::entry_t            push_data
);
    import fwbp_pkg::*;

    logic [WidthBits-1:0] bit_width_reg, bit_width_next;
    logic [WordBits-1:0]  acc_reg, acc_next;
    logic [HeldBits-1:0]  held_reg, held_next;

    logic [WidthBits-1:0] w;
    logic [WordBits-1:0]  mask;
    logic [WordBits-1:0]  v;
    logic [WidthBits-1:0] total;
    logic [WordBits-1:0]  acc_or;
    logic [WordBits-1:0]  carry;
    logic                 full;
    logic [HeldBits-1:0]  diff;
    logic [HeldBits-1:0]  part_held;
    logic [WordBits-1:0]  part_word;
    logic [WidthBits-1:0] part_round;
    logic                 accept;
    out_t                 full_res;
    out_t                 part_res;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        w      = (bit_width_reg > WidthMax) ? WidthMax : bit_width_reg;
        mask   = w[HeldBits] ? {WordBits{1'b1}}
                             : ((64'd1 << w[HeldBits-1:0]) - 64'd1);
        v      = in_data.value & mask;
        total  = {1'b0, held_reg} + w;
        acc_or = acc_reg | (v << held_reg);
        full   = total[HeldBits];
        diff   = total[HeldBits-1:0];
        // Bits of the value that did not fit; only used when held is 1 to 63.
        carry  = (v >> 1) >> (6'd63 - held_reg);

        part_held  = diff;
        part_word  = full ? ((diff != '0) ? carry : '0) : acc_or;
        part_round = {1'b0, part_held} + 7'd7;

        full_res.word        = acc_or;
        full_res.bytes_valid = FullBytes;
        full_res.final_res   = in_data.last && (diff == '0);

        part_res.word        = part_word;
        part_res.bytes_valid = part_round[WidthBits-1:3];
        part_res.final_res   = 1'b1;

        push_data = '0;
        push      = 1'b0;
        if (full)
        begin
            push_data.first  = full_res;
            push_data.second = part_res;
            push_data.two    = in_data.last && (part_held != '0);
            push             = accept;
        end
        else
        begin
            push_data.first = part_res;
            push            = accept && in_data.last && (part_held != '0);
        end

        acc_next  = acc_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (in_data.last)
            begin
                acc_next  = '0;
                held_next = '0;
            end
            else
            begin
                acc_next  = part_word;
                held_next = part_held;
            end
        end

        bit_width_next = cfg_valid ? cfg_data : bit_width_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_width_reg <= WidthReset;
            acc_reg       <= '0;
            held_reg      <= '0;
        end
        else
        begin
            bit_width_reg <= bit_width_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
        end
    end

endmodule

FILE: rtl/core/fwbp_queue.sv
module fwbp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fwbp_pkg::entry_t push_data,
    input  logic             pop,
    output fwbp_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import fwbp_pkg::*;

    entry_t             mem_reg [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCountW'(QDepth));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/fwbp_back.sv
module fwbp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fwbp_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    output fwbp_pkg::out_t   out_data,
    input  logic             out_stall
);
    import fwbp_pkg::*;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic sec_pend_reg, sec_pend_next;
    out_t sec_reg, sec_next;
    logic load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        load           = !out_valid_reg || !out_stall;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sec_pend_next  = sec_pend_reg;
        sec_next       = sec_reg;
        if (load)
        begin
            if (sec_pend_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = sec_reg;
                sec_pend_next  = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_data_next  = head.first;
                sec_next       = head.second;
                sec_pend_next  = head.two;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sec_reg      <= sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_pend_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_pend_reg  <= sec_pend_next;
        end
    end

endmodule

FILE: rtl/core/fixed_width_bit_packer_top.sv
// Fixed-width bit packer.
// Input words carry a value and a last mark on in_data, moved on in_valid with
// in_stall driven by this block. Each value is cut to its low bit_width bits and
// appended, least significant bit first, to a partial 64-bit output word.
// Output words carry the packed word, its count of valid low bytes and a final
// mark on out_data, moved on out_valid with out_stall driven by the receiver.
// The bit_width register is written through cfg_valid / cfg_data; cfg_ready is
// always high. Write it only while the block is idle.
// One input word is taken every cycle while the queue is not full. An item that
// yields a result passes through the queue and then the output register; an item
// that both fills a word and ends a run yields two output words, the second sent
// after the first. The throughput is therefore set by the single output
// register: one output word per cycle while out_stall is low. A four-entry queue
// lies between the packing front end and the output stage, so the input keeps
// flowing while the receiver stalls until that queue is full, when in_stall rises.
// Reset clears the partial word and bit count, empties the queue, drops
// out_valid and sets bit_width to 64.
module fixed_width_bit_packer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fwbp_pkg::WidthBits-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fwbp_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fwbp_pkg::out_t                 out_data
);
    import fwbp_pkg::*;

    logic   push;
    entry_t push_data;
    logic   pop;
    entry_t head;
    logic   q_empty;
    logic   q_full;

    // The register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // The front end packs each accepted value and queues each word that fills or ends a run.
    fwbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    fwbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // The back end splits each queued entry into one or two output words.
    fwbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

endmodule
